// ----- design/rsn_pkg.sv -----
// rsn_pkg: shared widths, constants and register codes of the ray-sphere normal shader
// no dependencies; imported by every design file of the block
package rsn_pkg;

  // stream and register widths
  localparam int COORD_W    = 16;
  localparam int RADIUS_W   = COORD_W - 1;
  localparam int CFG_ADDR_W = 2;
  localparam int IN_W       = 6 * COORD_W;
  localparam int CH_W       = 8;
  localparam int OUT_W      = 3 * CH_W;

  // internal widths of the exact integer datapath
  localparam int OC_W   = COORD_W + 1;   // origin minus center
  localparam int A_W    = 32;            // d.d
  localparam int H_W    = 35;            // oc.d
  localparam int C_W    = 36;            // oc.oc - r^2
  localparam int HS_W   = 36;            // h + floor(sqrt(discriminant))
  localparam int V_W    = 52;            // unnormalized normal component
  localparam int ROOT_W = 51;            // square root result
  localparam int RAD_W  = 2 * ROOT_W;    // square root radicand
  localparam int N_W    = 53;            // channel numerator before scaling
  localparam int DIV_W  = 74;            // channel divider datapath
  localparam int Q_W    = CH_W;          // quotient bits, one per divider stage

  // 255.999 as an exact ratio and the per-channel denominator factors
  localparam logic [17:0] K_SCALE = 18'd255999;
  localparam logic [14:0] K_HIT   = 15'd2000;
  localparam logic [14:0] K_RED   = 15'd4000;
  localparam logic [14:0] K_GRN   = 15'd20000;
  localparam logic [14:0] K_BLU   = 15'd1000;

  // front stages, sqrt, normal stages, sqrt, channel setup, divider
  localparam int PIPE_LAT = 5 + ROOT_W + 6 + ROOT_W + 2 + Q_W;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_CX = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_CY = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_CZ = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_R  = 2'd3;

endpackage

// ----- design/rsn_isqrt.sv -----
// rsn_isqrt: pipelined integer square root, one root bit per stage
// depends on rsn_pkg for RAD_W and ROOT_W
module rsn_isqrt import rsn_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [RAD_W-1:0]  rad_i,
  output logic [ROOT_W-1:0] root_o
);

  localparam int REM_W = ROOT_W + 3;

  logic [RAD_W-1:0]  rad_q  [ROOT_W];
  logic [REM_W-1:0]  rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];

  for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
    logic [RAD_W-1:0]  rad_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [REM_W-1:0]  cur;
    logic [REM_W-1:0]  trial;

    if (j == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
    end

    // bring down the next digit pair, try root*4+1
    assign cur   = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
    assign trial = REM_W'({root_in, 2'b01});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[j] <= rad_in << 2;
        if (cur >= trial) begin
          rem_q[j]  <= cur - trial;
          root_q[j] <= {root_in[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q[j]  <= cur;
          root_q[j] <= {root_in[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  assign root_o = root_q[ROOT_W-1];

endmodule

// ----- design/rsn_chdiv.sv -----
// rsn_chdiv: pipelined restoring divider for one 8-bit color channel
// depends on rsn_pkg for DIV_W and Q_W; quotient must fit in Q_W bits
module rsn_chdiv import rsn_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [DIV_W-1:0] num_i,
  input  logic [DIV_W-1:0] den_i,
  output logic [Q_W-1:0]   q_o
);

  logic [DIV_W-1:0] rem_q [Q_W];
  logic [DIV_W-1:0] den_q [Q_W];
  logic [Q_W-1:0]   q_q   [Q_W];

  for (genvar j = 0; j < Q_W; j++) begin : g_stage
    logic [DIV_W-1:0] rem_in;
    logic [DIV_W-1:0] den_in;
    logic [Q_W-1:0]   q_in;
    logic [DIV_W-1:0] sub;

    if (j == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign den_in = den_q[j-1];
      assign q_in   = q_q[j-1];
    end

    // quotient bits msb first
    assign sub = den_in << (Q_W - 1 - j);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[j] <= den_in;
        if (rem_in >= sub) begin
          rem_q[j] <= rem_in - sub;
          q_q[j]   <= {q_in[Q_W-2:0], 1'b1};
        end else begin
          rem_q[j] <= rem_in;
          q_q[j]   <= {q_in[Q_W-2:0], 1'b0};
        end
      end
    end
  end

  assign q_o = q_q[Q_W-1];

endmodule

// ----- design/ray_sphere_normal_shader_unit.sv -----
// ray_sphere_normal_shader_unit: top level of the ray-sphere normal shader
// depends on rsn_pkg, rsn_isqrt and rsn_chdiv
//
// One ray per transaction in, one pixel per transaction out, in order. Each ray
// (origin and direction, signed Q4.12) is tested exactly in integer arithmetic
// against the configured sphere; a hit in front of the origin is shaded by the
// unit normal mapped to 0..255 per channel with tuser = 1, anything else gets
// the white-to-blue sky gradient with tuser = 0. The block takes one ray every
// clock unless the output is stalled; most of its depth is in the two
// bit-serial square root pipelines (51 stages each, one for the discriminant and
// one for the normal length or the direction length) and the 8-stage channel
// divider. All stages advance together: when the output transaction is stalled
// the whole pipeline holds and s_axis_tready drops, so nothing is lost or
// repeated. Sphere registers are written through the cfg port (0: center x,
// 1: center y, 2: center z, 3: radius), by the user only while no ray is in
// flight (the block itself does not enforce it); there is no clearing pass after reset.
module ray_sphere_normal_shader_unit import rsn_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [COORD_W-1:0]    cfg_wdata_i,
  // ray input
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_W-1:0]       s_axis_tdata,   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  // pixel output
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_W-1:0]      m_axis_tdata,   // red, green, blue
  output logic                  m_axis_tuser    // hit
);

  // sphere registers
  logic signed [COORD_W-1:0] cx_q, cy_q, cz_q;
  logic [RADIUS_W-1:0]       rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q  <= '0;
      cy_q  <= '0;
      cz_q  <= -COORD_W'(16'sd4096);
      rad_q <= RADIUS_W'(2048);
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_CX: cx_q  <= cfg_wdata_i;
        CFG_CY: cy_q  <= cfg_wdata_i;
        CFG_CZ: cz_q  <= cfg_wdata_i;
        CFG_R:  rad_q <= cfg_wdata_i[RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  // global advance: everything moves unless the output is stalled
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // valid bits, one per pipeline stage
  logic [PIPE_LAT-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], s_axis_tvalid};
    end
  end

  assign m_axis_tvalid = vld_q[PIPE_LAT-1];

  // input fields
  logic signed [COORD_W-1:0] org [3];
  logic signed [COORD_W-1:0] dir [3];
  logic signed [COORD_W-1:0] ctr [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      org[i] = s_axis_tdata[i*COORD_W +: COORD_W];
      dir[i] = s_axis_tdata[(i+3)*COORD_W +: COORD_W];
    end
    ctr[0] = cx_q;
    ctr[1] = cy_q;
    ctr[2] = cz_q;
  end

  // stage 1: origin relative to the center
  logic signed [OC_W-1:0]    oc1_q [3];
  logic signed [COORD_W-1:0] d1_q  [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        oc1_q[i] <= OC_W'(org[i]) - OC_W'(ctr[i]);
        d1_q[i]  <= dir[i];
      end
    end
  end

  // stage 2: products for the quadratic terms
  logic signed [31:0]        dd2_q [3];
  logic signed [32:0]        od2_q [3];
  logic signed [33:0]        oo2_q [3];
  logic [2*RADIUS_W-1:0]     rr2_q;
  logic signed [OC_W-1:0]    oc2_q [3];
  logic signed [COORD_W-1:0] d2_q  [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dd2_q[i] <= d1_q[i] * d1_q[i];
        od2_q[i] <= oc1_q[i] * d1_q[i];
        oo2_q[i] <= oc1_q[i] * oc1_q[i];
        oc2_q[i] <= oc1_q[i];
        d2_q[i]  <= d1_q[i];
      end
      rr2_q <= rad_q * rad_q;
    end
  end

  // stage 3: a = d.d, h = oc.d, c = oc.oc - r^2
  logic [A_W-1:0]            a3_q;
  logic signed [H_W-1:0]     h3_q;
  logic signed [C_W-1:0]     c3_q;
  logic signed [OC_W-1:0]    oc3_q [3];
  logic signed [COORD_W-1:0] d3_q  [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      a3_q <= A_W'(dd2_q[0]) + A_W'(dd2_q[1]) + A_W'(dd2_q[2]);
      h3_q <= H_W'(od2_q[0]) + H_W'(od2_q[1]) + H_W'(od2_q[2]);
      c3_q <= C_W'(oo2_q[0]) + C_W'(oo2_q[1]) + C_W'(oo2_q[2])
              - C_W'($signed({1'b0, rr2_q}));
      for (int i = 0; i < 3; i++) begin
        oc3_q[i] <= oc2_q[i];
        d3_q[i]  <= d2_q[i];
      end
    end
  end

  // stage 4: h*h and a*c
  logic signed [2*H_W-1:0]   hh4_q;
  logic signed [A_W+C_W:0]   ac4_q;
  logic [A_W-1:0]            a4_q;
  logic signed [H_W-1:0]     h4_q;
  logic signed [C_W-1:0]     c4_q;
  logic signed [OC_W-1:0]    oc4_q [3];
  logic signed [COORD_W-1:0] d4_q  [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      hh4_q <= h3_q * h3_q;
      ac4_q <= $signed({1'b0, a3_q}) * c3_q;
      a4_q  <= a3_q;
      h4_q  <= h3_q;
      c4_q  <= c3_q;
      for (int i = 0; i < 3; i++) begin
        oc4_q[i] <= oc3_q[i];
        d4_q[i]  <= d3_q[i];
      end
    end
  end

  // stage 5: discriminant and hit test, t >= 0 exactly when h <= 0 and c >= 0
  typedef struct packed {
    logic                        hit;
    logic [2:0][OC_W-1:0]        oc;
    logic [2:0][COORD_W-1:0]     d;
    logic [A_W-1:0]              a;
    logic [H_W-1:0]              h;
  } sq1_t;

  logic signed [2*H_W:0] disc_d;
  logic                  hit_d;
  sq1_t                  s5_d;
  sq1_t                  s5_q;
  logic [RAD_W-1:0]      rad1_q;

  always_comb begin
    disc_d = (2*H_W+1)'(hh4_q) - (2*H_W+1)'(ac4_q);
    hit_d  = (a4_q != '0) && !disc_d[2*H_W] && (h4_q[H_W-1] || (h4_q == '0))
             && !c4_q[C_W-1];
    s5_d.hit = hit_d;
    for (int i = 0; i < 3; i++) begin
      s5_d.oc[i] = oc4_q[i];
      s5_d.d[i]  = d4_q[i];
    end
    s5_d.a = a4_q;
    s5_d.h = h4_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_q   <= s5_d;
      rad1_q <= hit_d ? RAD_W'(disc_d[2*H_W-3:0]) : '0;
    end
  end

  // first square root: floor(sqrt(discriminant)), payload rides alongside
  logic [ROOT_W-1:0] root1;
  sq1_t              sq1_q [ROOT_W];

  rsn_isqrt u_sqrt_disc (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rad1_q),
    .root_o (root1)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq1_q[0] <= s5_q;
      for (int j = 1; j < ROOT_W; j++) sq1_q[j] <= sq1_q[j-1];
    end
  end

  // stage A: hs = h + s, never positive on a hit
  sq1_t                  pa;
  logic signed [HS_W-1:0] hsA_q;
  sq1_t                  pA_q;

  assign pa = sq1_q[ROOT_W-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      hsA_q <= HS_W'($signed(pa.h)) + $signed({2'b00, root1[HS_W-3:0]});
      pA_q  <= pa;
    end
  end

  // stage B: a*oc and hs*d
  logic signed [A_W+OC_W:0]   aoB_q [3];
  logic signed [HS_W+COORD_W-1:0] hdB_q [3];
  logic [A_W-1:0]             aB_q;
  logic signed [COORD_W-1:0]  dyB_q;
  logic                       hitB_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        aoB_q[i] <= $signed({1'b0, pA_q.a}) * $signed(pA_q.oc[i]);
        hdB_q[i] <= hsA_q * $signed(pA_q.d[i]);
      end
      aB_q   <= pA_q.a;
      dyB_q  <= $signed(pA_q.d[1]);
      hitB_q <= pA_q.hit;
    end
  end

  // stage C: normal direction V = a*oc - hs*d
  logic signed [V_W-1:0]     vC_q [3];
  logic [A_W-1:0]            aC_q;
  logic signed [COORD_W-1:0] dyC_q;
  logic                      hitC_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) vC_q[i] <= V_W'(aoB_q[i]) - V_W'(hdB_q[i]);
      aC_q   <= aB_q;
      dyC_q  <= dyB_q;
      hitC_q <= hitB_q;
    end
  end

  // stage D: squares of |V| as three partial products each
  logic [V_W-1:0]            mag_d [3];
  logic [51:0]               phh_q [3];
  logic [50:0]               phl_q [3];
  logic [49:0]               pll_q [3];
  logic signed [V_W-1:0]     vD_q  [3];
  logic [A_W-1:0]            aD_q;
  logic signed [COORD_W-1:0] dyD_q;
  logic                      hitD_q;

  always_comb begin
    for (int i = 0; i < 3; i++) mag_d[i] = vC_q[i][V_W-1] ? V_W'(-vC_q[i]) : V_W'(vC_q[i]);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        phh_q[i] <= mag_d[i][50:25] * mag_d[i][50:25];
        phl_q[i] <= mag_d[i][50:25] * mag_d[i][24:0];
        pll_q[i] <= mag_d[i][24:0] * mag_d[i][24:0];
        vD_q[i]  <= vC_q[i];
      end
      aD_q   <= aC_q;
      dyD_q  <= dyC_q;
      hitD_q <= hitC_q;
    end
  end

  // stage E: V_i^2 assembled
  logic [RAD_W-1:0]          sqE_q [3];
  logic signed [V_W-1:0]     vE_q  [3];
  logic [A_W-1:0]            aE_q;
  logic signed [COORD_W-1:0] dyE_q;
  logic                      hitE_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sqE_q[i] <= (RAD_W'(phh_q[i]) << 50) + (RAD_W'(phl_q[i]) << 26) + RAD_W'(pll_q[i]);
        vE_q[i]  <= vD_q[i];
      end
      aE_q   <= aD_q;
      dyE_q  <= dyD_q;
      hitE_q <= hitD_q;
    end
  end

  // stage F: radicand for the length, V.V on a hit, d.d for the sky
  typedef struct packed {
    logic                    hit;
    logic [2:0][V_W-1:0]     v;
    logic [COORD_W-1:0]      dy;
  } sq2_t;

  logic [RAD_W-1:0] vv_d;
  logic [RAD_W-1:0] rad2_q;
  sq2_t             pF_q;

  assign vv_d = sqE_q[0] + sqE_q[1] + sqE_q[2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad2_q  <= hitE_q ? vv_d : RAD_W'(aE_q);
      pF_q.hit <= hitE_q;
      for (int i = 0; i < 3; i++) pF_q.v[i] <= vE_q[i];
      pF_q.dy <= dyE_q;
    end
  end

  // second square root: length L
  logic [ROOT_W-1:0] root2;
  sq2_t              sq2_q [ROOT_W];

  rsn_isqrt u_sqrt_len (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rad2_q),
    .root_o (root2)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq2_q[0] <= pF_q;
      for (int j = 1; j < ROOT_W; j++) sq2_q[j] <= sq2_q[j-1];
    end
  end

  // stage G: channel numerators; zero length means zero normal with L = 1
  sq2_t                  pg;
  logic                  lz;
  logic [ROOT_W-1:0]     le_d;
  logic signed [N_W-1:0] les;
  logic signed [N_W-1:0] dys;
  logic signed [N_W-1:0] n_d [3];
  logic [N_W-1:0]        nG_q [3];
  logic [ROOT_W-1:0]     leG_q;
  logic                  hitG_q;

  assign pg = sq2_q[ROOT_W-1];

  always_comb begin
    lz   = (root2 == '0);
    le_d = lz ? ROOT_W'(1) : root2;
    les  = $signed(N_W'(le_d));
    dys  = N_W'($signed(pg.dy));
    if (pg.hit) begin
      for (int i = 0; i < 3; i++) begin
        n_d[i] = (lz ? '0 : N_W'($signed(pg.v[i]))) + les;
      end
    end else begin
      n_d[0] = les * 3 - dys;
      n_d[1] = les * 17 - dys * 3;
      n_d[2] = les;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) nG_q[i] <= n_d[i];
      leG_q  <= le_d;
      hitG_q <= pg.hit;
    end
  end

  // stage H: scale numerator by 255999, denominator by the channel factor
  logic [14:0]      k_d   [3];
  logic [DIV_W-1:0] numH_q [3];
  logic [DIV_W-1:0] denH_q [3];
  logic             hitH_q;

  always_comb begin
    if (hitG_q) begin
      for (int i = 0; i < 3; i++) k_d[i] = K_HIT;
    end else begin
      k_d[0] = K_RED;
      k_d[1] = K_GRN;
      k_d[2] = K_BLU;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        numH_q[i] <= DIV_W'(nG_q[i]) * DIV_W'(K_SCALE);
        denH_q[i] <= DIV_W'(leG_q) * DIV_W'(k_d[i]);
      end
      hitH_q <= hitG_q;
    end
  end

  // channel dividers, the last stage is the output register
  logic [Q_W-1:0] chan [3];
  logic [Q_W-1:0] hitdl_q;

  for (genvar i = 0; i < 3; i++) begin : g_chan
    rsn_chdiv u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (numH_q[i]),
      .den_i (denH_q[i]),
      .q_o   (chan[i])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) hitdl_q <= {hitdl_q[Q_W-2:0], hitH_q};
  end

  assign m_axis_tdata = {chan[2], chan[1], chan[0]};
  assign m_axis_tuser = hitdl_q[Q_W-1];

endmodule

// ----- design/rsn_checker.sv -----
// rsn_checker: port-level assertions for ray_sphere_normal_shader_unit
// depends on rsn_pkg; bound to the top level below
module rsn_checker import rsn_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_W-1:0]      m_axis_tdata,
  input logic                  m_axis_tuser
);

  // stalled output transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("output transaction changed while stalled");

  // input side only backs up when the output is stalled
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
    else $error("input not ready while output free");

  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while output stalled");

  // sky pixels always have full blue
  a_sky_blue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[OUT_W-1 -: CH_W] == 8'hFF)
    else $error("sky pixel without full blue");

endmodule

bind ray_sphere_normal_shader_unit rsn_checker u_rsn_checker (.*);

// ----- tb/ray_sphere_normal_shader_unit_tb.sv -----
// ray_sphere_normal_shader_unit_tb: self-checking bench for the ray-sphere normal shader
// depends on rsn_pkg and the design files; predicts every pixel with wide exact integers
`timescale 1ns / 100ps

module ray_sphere_normal_shader_unit_tb;
  import rsn_pkg::*;

  // wide enough for every product in the exact datapath, with room for the sign
  typedef logic signed [191:0] wide_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] ox, oy, oz, dx, dy, dz;
  } ray_t;

  typedef struct packed {
    logic [CH_W-1:0] red, green, blue;
    logic            hit;
  } pixel_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [COORD_W-1:0]    cfg_wdata_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_W-1:0]       s_axis_tdata = '0;   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_W-1:0]      m_axis_tdata;        // red, green, blue
  logic                  m_axis_tuser;        // hit

  // shadow copy of the sphere registers
  logic signed [COORD_W-1:0] ctr_x = '0, ctr_y = '0, ctr_z = -16'sd4096;
  logic [RADIUS_W-1:0]       radius = 15'd2048;

  pixel_t pixels_pending[$];
  int     mismatches = 0;
  bit     steady = 1'b0;   // no idling on either side in the closing stretch

  ray_sphere_normal_shader_unit dut (.*);

  always #5 clk_i = ~clk_i;

  // floor square root of a non-negative value
  function automatic wide_t root_floor(wide_t n);
    wide_t r, c;
    r = '0;
    for (int i = 95; i >= 0; i--) begin
      c = r;
      c[i] = 1'b1;
      if ($unsigned(c * c) <= $unsigned(n)) r = c;
    end
    return r;
  endfunction

  // floor(num / den) clamped to one channel; den positive
  function automatic logic [CH_W-1:0] clamp_channel(wide_t num, wide_t den);
    wide_t q;
    if (num < 0) return '0;
    q = num / den;
    if (q > 255) return 8'd255;
    return q[CH_W-1:0];
  endfunction

  // exact shading of one ray against the shadow sphere
  function automatic pixel_t shade_ray(ray_t ray);
    wide_t oc[3], d[3], v[3];
    wide_t a, h, c, disc, hs, len, sum, den, scale;
    pixel_t px;
    scale = 255999;
    oc[0] = wide_t'(ray.ox) - wide_t'(ctr_x);
    oc[1] = wide_t'(ray.oy) - wide_t'(ctr_y);
    oc[2] = wide_t'(ray.oz) - wide_t'(ctr_z);
    d[0] = ray.dx;
    d[1] = ray.dy;
    d[2] = ray.dz;
    a = 0; h = 0; c = 0;
    for (int i = 0; i < 3; i++) begin
      a += d[i] * d[i];
      h += oc[i] * d[i];
      c += oc[i] * oc[i];
    end
    c -= wide_t'({1'b0, radius}) * wide_t'({1'b0, radius});
    disc = h * h - a * c;
    if (a != 0 && disc >= 0 && h <= 0 && c >= 0) begin
      hs = h + root_floor(disc);
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        v[i] = a * oc[i] - hs * d[i];
        sum += v[i] * v[i];
      end
      len = root_floor(sum);
      // degenerate normal: treated as zero length, every channel mid-gray
      if (len == 0) begin
        len = 1;
        for (int i = 0; i < 3; i++) v[i] = 0;
      end
      den = len * 2000;
      px.red   = clamp_channel((v[0] + len) * scale, den);
      px.green = clamp_channel((v[1] + len) * scale, den);
      px.blue  = clamp_channel((v[2] + len) * scale, den);
      px.hit   = 1'b1;
    end else begin
      len = root_floor(a);
      if (len == 0) len = 1;
      px.red   = clamp_channel((len * 3 - d[1]) * scale, len * 4000);
      px.green = clamp_channel((len * 17 - d[1] * 3) * scale, len * 20000);
      px.blue  = 8'd255;
      px.hit   = 1'b0;
    end
    return px;
  endfunction

  // sink side: random backpressure bursts and the pixel checker
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      pixel_t got, want;
      got = {m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16], m_axis_tuser};
      if (pixels_pending.size() == 0) begin
        mismatches++;
        $display("%0t: pixel with no ray outstanding, actual %h", $time, got);
      end else begin
        want = pixels_pending.pop_front();
        if (got.red !== want.red)
          $display("%0t: red expected %0d actual %0d", $time, want.red, got.red);
        if (got.green !== want.green)
          $display("%0t: green expected %0d actual %0d", $time, want.green, got.green);
        if (got.blue !== want.blue)
          $display("%0t: blue expected %0d actual %0d", $time, want.blue, got.blue);
        if (got.hit !== want.hit)
          $display("%0t: hit expected %0d actual %0d", $time, want.hit, got.hit);
        if (got !== want) mismatches++;
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= (stall_left == 0);
    end else if (!steady && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 7);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // one ray transaction, with an optional idle burst ahead of it
  task automatic send_ray(ray_t ray);
    if (!steady && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ray.dz, ray.dy, ray.dx, ray.oz, ray.oy, ray.ox};
    do @(posedge clk_i); while (!s_axis_tready);
    pixels_pending.push_back(shade_ray(ray));
  endtask

  // let everything in flight come out before touching the registers
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pixels_pending.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [COORD_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_CX: ctr_x = val;
      CFG_CY: ctr_y = val;
      CFG_CZ: ctr_z = val;
      CFG_R:  radius = val[RADIUS_W-1:0];
    endcase
  endtask

  task automatic set_sphere(logic [15:0] cx, logic [15:0] cy, logic [15:0] cz,
                            logic [15:0] r);
    write_reg(CFG_CX, cx);
    write_reg(CFG_CY, cy);
    write_reg(CFG_CZ, cz);
    write_reg(CFG_R, r);
  endtask

  function automatic logic [15:0] rnd16();
    return 16'($urandom);
  endfunction

  // ray aimed roughly at the sphere from near its front, so most of them hit
  function automatic ray_t aimed_ray();
    ray_t ray;
    ray.ox = ctr_x + 16'($signed($urandom_range(0, 2048)) - 1024);
    ray.oy = ctr_y + 16'($signed($urandom_range(0, 2048)) - 1024);
    ray.oz = ctr_z + 16'sd4096 + 16'($urandom_range(0, 4096));
    ray.dx = 16'($signed($urandom_range(0, 4096)) - 2048);
    ray.dy = 16'($signed($urandom_range(0, 4096)) - 2048);
    ray.dz = -16'sd4096 - 16'($urandom_range(0, 8192));
    return ray;
  endfunction

  function automatic ray_t noise_ray();
    return ray_t'({rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16()});
  endfunction

  // corner cases at the reset sphere (center z -1.0, radius 0.5)
  task automatic test_directed;
    send_ray('{0, 0, 0, 0, 0, 0});                            // zero direction
    send_ray('{0, 0, 0, 0, 0, -4096});                        // dead center hit
    send_ray('{0, 0, 0, 0, 4096, 0});                         // straight up
    send_ray('{0, 0, 0, 0, -4096, 0});                        // straight down
    send_ray('{0, 0, -4096, 4096, 0, 0});                     // origin inside
    send_ray('{0, 0, 0, 0, 0, 4096});                         // sphere behind
    send_ray('{0, 0, 0, 2048, 0, -4096});                     // grazing
    send_ray('{-32768, -32768, -32768, -32768, -32768, -32768});
    send_ray('{32767, 32767, 32767, 32767, 32767, 32767});
    send_ray('{0, 0, 0, 32767, -32768, 32767});
    send_ray('{0, 0, 32767, 0, 0, -32768});                   // far origin, long dir
    send_ray('{-1, -1, -1, -1, -1, -1});
    drain();
    // zero radius with the ray through the center: degenerate normal
    write_reg(CFG_R, 16'h0000);
    send_ray('{0, 0, 0, 0, 0, -4096});
    send_ray('{0, 0, 0, 0, 0, -1});
    drain();
    // top bit of the radius write lands outside the register
    set_sphere(16'h7fff, 16'h8000, 16'h8000, 16'hffff);
    send_ray('{32767, -32768, 0, 0, 0, -32768});
    send_ray('{-32768, 32767, -32768, 32767, 0, 0});
    send_ray('{0, 0, 0, 0, 0, 0});
    drain();
  endtask

  // one sphere setting, mostly aimed rays and some noise
  task automatic run_phase(int count);
    for (int i = 0; i < count; i++)
      send_ray(($urandom_range(0, 3) != 0) ? aimed_ray() : noise_ray());
  endtask

  task automatic test_random;
    set_sphere(16'h0000, 16'h0000, -16'sd4096, 16'd2048);
    run_phase(300);
    drain();
    set_sphere(16'h8000, 16'h7fff, 16'h0000, 16'h7fff);   // extreme center, largest radius
    run_phase(200);
    drain();
    for (int p = 0; p < 4; p++) begin
      set_sphere(16'($signed($urandom_range(0, 16384)) - 8192),
                 16'($signed($urandom_range(0, 16384)) - 8192),
                 16'($signed($urandom_range(0, 16384)) - 8192), rnd16());
      run_phase(200);
      drain();
    end
    set_sphere(16'h0400, 16'hfc00, -16'sd8192, 16'd1);   // tiny sphere
    run_phase(150);
    drain();
    set_sphere(16'h0000, 16'h0000, -16'sd4096, 16'd3000);
    run_phase(150);
    steady = 1'b1;
    run_phase(150);
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/rsn_pkg.sv
design/rsn_isqrt.sv
design/rsn_chdiv.sv
design/ray_sphere_normal_shader_unit.sv
design/rsn_checker.sv
tb/ray_sphere_normal_shader_unit_tb.sv
